// ===== rtl/core/msec_pkg.sv =====
// ----------------------------------------------------------------------------
// msec_pkg
// Shared types, codes and constants of the MIPS subset execute core.
// ----------------------------------------------------------------------------
package msec_pkg;

    localparam int NUM_REGS_DEF   = 32;
    localparam int DMEM_WORDS_DEF = 256;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_MUL = 6'b011000;
    localparam logic [5:0] FN_ADD = 6'b100000;
    localparam logic [5:0] FN_SUB = 6'b100010;
    localparam logic [5:0] FN_AND = 6'b100100;
    localparam logic [5:0] FN_OR  = 6'b100101;
    localparam logic [5:0] FN_XOR = 6'b100110;
    localparam logic [5:0] FN_NOR = 6'b100111;
    localparam logic [5:0] FN_SLT = 6'b101010;

    localparam logic [31:0] JUMP_MASK = 32'h03ff_ffff;
    localparam logic [15:0] IMM_MASK  = 16'hffff;

    typedef enum logic [3:0] {
        T_CLS_PRELOAD,
        T_CLS_RTYPE,
        T_CLS_LW,
        T_CLS_SW,
        T_CLS_BEQ,
        T_CLS_BNE,
        T_CLS_ADDI,
        T_CLS_SLTI,
        T_CLS_J,
        T_CLS_BAD
    } t_cls;

    typedef struct packed {
        logic        kind;
        logic [31:0] instr_word;
        logic [7:0]  preload_index;
        logic [31:0] preload_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [7:0]  mem_index;
        logic [31:0] mem_value;
        logic        bad_opcode;
    } t_out_item;

    // Decoded transaction passed from the front to the back.
    typedef struct packed {
        t_cls        cls;
        logic [31:0] instr_word;
        logic [7:0]  preload_index;
        logic [31:0] preload_value;
    } t_dec_item;

endpackage

// ===== rtl/core/msec_front.sv =====
// ----------------------------------------------------------------------------
// msec_front
// Classify incoming transactions and hold them in a short queue.
// ----------------------------------------------------------------------------
module msec_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  msec_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output msec_pkg::t_dec_item  o_data
);
    msec_pkg::t_dec_item r_q [msec_pkg::QUEUE_DEPTH];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    msec_pkg::t_dec_item w_dec;
    logic                w_push, w_pop;

    always_comb begin
        w_dec.instr_word    = i_data.instr_word;
        w_dec.preload_index = i_data.preload_index;
        w_dec.preload_value = i_data.preload_value;
        if (i_data.kind) begin
            w_dec.cls = msec_pkg::T_CLS_PRELOAD;
        end else begin
            case (i_data.instr_word[31:26])
                msec_pkg::OP_RTYPE: w_dec.cls = msec_pkg::T_CLS_RTYPE;
                msec_pkg::OP_LW:    w_dec.cls = msec_pkg::T_CLS_LW;
                msec_pkg::OP_SW:    w_dec.cls = msec_pkg::T_CLS_SW;
                msec_pkg::OP_BEQ:   w_dec.cls = msec_pkg::T_CLS_BEQ;
                msec_pkg::OP_BNE:   w_dec.cls = msec_pkg::T_CLS_BNE;
                msec_pkg::OP_ADDI:  w_dec.cls = msec_pkg::T_CLS_ADDI;
                msec_pkg::OP_SLTI:  w_dec.cls = msec_pkg::T_CLS_SLTI;
                msec_pkg::OP_J:     w_dec.cls = msec_pkg::T_CLS_J;
                default:            w_dec.cls = msec_pkg::T_CLS_BAD;
            endcase
        end
    end

    assign o_stall = (r_cnt == 2'(msec_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_dec;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(msec_pkg::QUEUE_DEPTH)) else $error("queue overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count slip");
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> r_wp == r_rp) else $error("pointer mismatch");
endmodule

// ===== rtl/core/msec_back.sv =====
// ----------------------------------------------------------------------------
// msec_back
// Execute decoded transactions against pc, register file and data memory.
// ----------------------------------------------------------------------------
module msec_back #(
    parameter int NUM_REGS   = msec_pkg::NUM_REGS_DEF,
    parameter int DMEM_WORDS = msec_pkg::DMEM_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  msec_pkg::t_dec_item  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output msec_pkg::t_out_item  o_data
);
    localparam int AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
    localparam int IW = $clog2(NUM_REGS);

    // Flip-flop register file; data memory in a RAM with registered read.
    logic [31:0]          r_rf [NUM_REGS];
    logic [31:0]          r_pc;
    logic                 r_ovalid;
    msec_pkg::t_out_item  r_out;
    logic                 r_out_ld;
    logic                 r_ld_wb;
    logic [4:0]           r_ld_dst;
    logic                 r_clr;
    logic [AW-1:0]        r_clr_idx;

    logic        w_go;
    logic [4:0]  w_rs, w_rt, w_rd;
    logic [31:0] w_a, w_b, w_simm, w_seq, w_npc, w_val, w_ea;
    logic [63:0] w_prod;
    logic [AW-1:0] w_midx;
    logic [4:0]  w_dst;
    logic        w_wr, w_mwr, w_bad, w_ld;
    logic [31:0] w_mval;
    msec_pkg::t_out_item w_res;
    logic          w_ram_we, w_ram_re;
    logic [AW-1:0] w_ram_waddr;
    logic [31:0]   w_ram_wdata, w_rdata;

    // A pending load value comes from the RAM output until it is written back.
    function automatic logic [31:0] rd_reg(input logic [4:0] n,
                                           input logic [31:0] v,
                                           input logic fwd,
                                           input logic [31:0] fv);
        if (n == 5'd0 || 32'(n) >= NUM_REGS) return 32'd0;
        if (fwd) return fv;
        return v;
    endfunction

    assign o_stall = r_clr || (r_ovalid && i_stall);
    assign w_go    = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_comb begin
        o_data = r_out;
        if (r_out_ld) o_data.reg_value = w_rdata;
    end

    always_comb begin
        w_rs   = i_data.instr_word[25:21];
        w_rt   = i_data.instr_word[20:16];
        w_rd   = i_data.instr_word[15:11];
        w_a    = rd_reg(w_rs, r_rf[w_rs[IW-1:0]], r_ld_wb && (w_rs == r_ld_dst), w_rdata);
        w_b    = rd_reg(w_rt, r_rf[w_rt[IW-1:0]], r_ld_wb && (w_rt == r_ld_dst), w_rdata);
        w_simm = {{16{i_data.instr_word[15]}}, i_data.instr_word[15:0] & msec_pkg::IMM_MASK};
        w_seq  = r_pc + 32'd4;
        w_npc  = w_seq;
        w_ea   = w_a + w_simm;
        w_prod = 64'(w_a) * 64'(w_b);
        w_val  = 32'd0;
        w_dst  = 5'd0;
        w_wr   = 1'b0;
        w_mwr  = 1'b0;
        w_mval = 32'd0;
        w_bad  = 1'b0;
        w_ld   = 1'b0;
        w_midx = w_ea[AW+1:2];
        case (i_data.cls)
            msec_pkg::T_CLS_PRELOAD: begin
                w_npc  = r_pc;
                w_midx = AW'(i_data.preload_index);
                w_mwr  = 1'b1;
                w_mval = i_data.preload_value;
            end
            msec_pkg::T_CLS_RTYPE: begin
                w_dst = w_rd;
                w_wr  = 1'b1;
                case (i_data.instr_word[5:0])
                    msec_pkg::FN_ADD: w_val = w_a + w_b;
                    msec_pkg::FN_SUB: w_val = w_a - w_b;
                    msec_pkg::FN_AND: w_val = w_a & w_b;
                    msec_pkg::FN_OR:  w_val = w_a | w_b;
                    msec_pkg::FN_XOR: w_val = w_a ^ w_b;
                    msec_pkg::FN_NOR: w_val = ~(w_a | w_b);
                    msec_pkg::FN_MUL: w_val = w_prod[31:0];
                    msec_pkg::FN_SLT: w_val = 32'($signed(w_a) < $signed(w_b));
                    default:          w_val = 32'd0;
                endcase
            end
            msec_pkg::T_CLS_LW: begin
                // Value arrives from the RAM's registered read in the next cycle.
                w_dst = w_rt; w_wr = 1'b1; w_ld = 1'b1;
            end
            msec_pkg::T_CLS_SW: begin
                w_mwr = 1'b1; w_mval = w_b;
            end
            msec_pkg::T_CLS_BEQ: if (w_a == w_b) w_npc = w_seq + (w_simm << 2);
            msec_pkg::T_CLS_BNE: if (w_a != w_b) w_npc = w_seq + (w_simm << 2);
            msec_pkg::T_CLS_ADDI: begin
                w_val = w_ea; w_dst = w_rt; w_wr = 1'b1;
            end
            msec_pkg::T_CLS_SLTI: begin
                w_val = 32'($signed(w_a) < $signed(w_simm)); w_dst = w_rt; w_wr = 1'b1;
            end
            msec_pkg::T_CLS_J:
                w_npc = {w_seq[31:28], 28'((i_data.instr_word & msec_pkg::JUMP_MASK) << 2)};
            default: w_bad = 1'b1;
        endcase
        if (w_dst == 5'd0 || 32'(w_dst) >= NUM_REGS) w_wr = 1'b0;
        w_ld = w_ld && w_wr;
        w_res.next_pc     = w_npc;
        w_res.reg_written = w_wr;
        w_res.reg_index   = w_wr ? w_dst : 5'd0;
        w_res.reg_value   = (w_wr && !w_ld) ? w_val : 32'd0;
        w_res.mem_written = w_mwr;
        w_res.mem_index   = w_mwr ? 8'(w_midx) : 8'd0;
        w_res.mem_value   = w_mval;
        w_res.bad_opcode  = w_bad;
    end

    // One RAM write port, shared by the clearing pass and stores/preloads.
    assign w_ram_we    = r_clr || (w_go && w_mwr);
    assign w_ram_waddr = r_clr ? r_clr_idx : w_midx;
    assign w_ram_wdata = r_clr ? 32'd0 : w_mval;
    assign w_ram_re    = w_go && w_ld;

    msec_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .i_clk,
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_ram_re),
        .i_raddr(w_midx),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= 32'd0;
            r_ovalid  <= 1'b0;
            r_out_ld  <= 1'b0;
            r_ld_wb   <= 1'b0;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(DMEM_WORDS - 1)) r_clr <= 1'b0;
            end
            r_ld_wb <= w_go && w_ld;
            if (w_go) begin
                r_pc     <= w_npc;
                r_out_ld <= w_ld;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out    <= w_res;
            r_ld_dst <= w_dst;
        end
    end

    // Newer register write wins over a load write-back to the same register.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_REGS; i++) begin
            if (!i_rst_n) begin
                r_rf[i] <= 32'd0;
            end else if (w_go && w_wr && !w_ld && w_dst == 5'(i)) begin
                r_rf[i] <= w_val;
            end else if (r_ld_wb && r_ld_dst == 5'(i)) begin
                r_rf[i] <= w_rdata;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_out)) else $error("result lost");
    a_pre_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && i_data.cls == msec_pkg::T_CLS_PRELOAD |=> $stable(r_pc))
        else $error("preload moved pc");
    a_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.reg_written |-> r_out.reg_index != 5'd0)
        else $error("write to r0");
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !w_go) else $error("execute during clear");
endmodule

// ----------------------------------------------------------------------------
// msec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/mips_subset_execute_core_unit.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_core_unit
// MIPS subset execute core: one instruction or preload per transaction.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall, i_data): each transaction is either an
// instruction fetched at the current pc or a data memory preload.
// Output channel (o_valid / i_stall, o_data): exactly one result per input
// transaction, in order: next pc, register write, memory write, bad opcode.
// The front classifies the opcode and pushes into a two-entry queue; the
// back executes from the queue head into an output register.
// Throughput: one transaction per cycle unless the clear or receiver stalls.
// Input passes the queue and output registers. The register file sits in
// flip-flops; data memory is a RAM with registered read, and a load value
// is forwarded from the RAM output to the next instruction.
// Reset: pc and register file clear at once; the back then clears data
// memory one word per cycle, all DMEM_WORDS words (256 by default), during
// which the queue takes two transactions and o_stall then holds high.
// When the receiver stalls, hold the result; the back then stalls, the
// queue fills and o_stall rises once two transactions wait in it.
// ----------------------------------------------------------------------------
module mips_subset_execute_core_unit #(
    parameter int NUM_REGS   = msec_pkg::NUM_REGS_DEF,
    parameter int DMEM_WORDS = msec_pkg::DMEM_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  msec_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output msec_pkg::t_out_item o_data
);
    logic                q_valid, q_stall;
    msec_pkg::t_dec_item q_data;

    // Front: classify and queue.
    msec_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid(q_valid), .i_stall(q_stall), .o_data(q_data)
    );

    // Back: execute and register the result.
    msec_back #(.NUM_REGS(NUM_REGS), .DMEM_WORDS(DMEM_WORDS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_data(q_data),
        .o_valid, .i_stall, .o_data
    );
endmodule

// ===== tb/mips_subset_execute_core_unit_tb.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_core_unit_tb
// Drives instruction and preload transactions into the execute core, predicts
// pc, register and memory effects per transaction and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mips_subset_execute_core_unit_tb;

    localparam int NREG        = 32;
    localparam int NWORDS      = 256;
    localparam int RANDOM_ITEMS = 900;
    localparam int WATCHDOG    = 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    msec_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    msec_pkg::t_out_item o_data;

    mips_subset_execute_core_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Shadow architectural state for the predictor.
    logic [31:0] arch_pc;
    logic [31:0] arch_regs [NREG];
    logic [31:0] arch_dmem [NWORDS];

    msec_pkg::t_out_item pending_results [$];
    int          errors;
    int          idle_cycles;
    bit          quiet;       // no idling in the last part of the run

    // Directed table: the expected result is typed in only where trivial.
    typedef struct {
        msec_pkg::t_in_item  item;
        bit                  has_fixed;
        msec_pkg::t_out_item fixed;
    } t_row;
    t_row table_rows [$];

    function automatic logic [31:0] read_reg(logic [4:0] n);
        if (n == 5'd0) return 32'd0;
        return arch_regs[n];
    endfunction

    // Retire one transaction on the shadow state and return its result.
    function automatic msec_pkg::t_out_item retire(msec_pkg::t_in_item it);
        msec_pkg::t_out_item r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, dst;
        logic [31:0] a, b, simm, seq, npc, val, addr;
        bit          wr;
        r = '0;
        if (it.kind) begin
            arch_dmem[it.preload_index] = it.preload_value;
            r.mem_written = 1'b1;
            r.mem_index   = it.preload_index;
            r.mem_value   = it.preload_value;
        end else begin
            op   = it.instr_word[31:26];
            rs   = it.instr_word[25:21];
            rt   = it.instr_word[20:16];
            rd   = it.instr_word[15:11];
            fn   = it.instr_word[5:0];
            simm = {{16{it.instr_word[15]}}, it.instr_word[15:0]};
            a    = read_reg(rs);
            b    = read_reg(rt);
            seq  = arch_pc + 32'd4;
            npc  = seq;
            val  = '0;
            dst  = '0;
            wr   = 0;
            addr = a + simm;
            case (op)
                msec_pkg::OP_RTYPE: begin
                    case (fn)
                        msec_pkg::FN_ADD: val = a + b;
                        msec_pkg::FN_SUB: val = a - b;
                        msec_pkg::FN_AND: val = a & b;
                        msec_pkg::FN_OR:  val = a | b;
                        msec_pkg::FN_XOR: val = a ^ b;
                        msec_pkg::FN_NOR: val = ~(a | b);
                        msec_pkg::FN_MUL: val = a * b;
                        msec_pkg::FN_SLT: val = {31'd0, $signed(a) < $signed(b)};
                        default: val = '0;
                    endcase
                    dst = rd; wr = 1;
                end
                msec_pkg::OP_LW: begin
                    val = arch_dmem[addr[9:2]]; dst = rt; wr = 1;
                end
                msec_pkg::OP_SW: begin
                    arch_dmem[addr[9:2]] = b;
                    r.mem_written = 1'b1;
                    r.mem_index   = addr[9:2];
                    r.mem_value   = b;
                end
                msec_pkg::OP_BEQ: if (a == b) npc = seq + (simm << 2);
                msec_pkg::OP_BNE: if (a != b) npc = seq + (simm << 2);
                msec_pkg::OP_ADDI: begin
                    val = a + simm; dst = rt; wr = 1;
                end
                msec_pkg::OP_SLTI: begin
                    val = {31'd0, $signed(a) < $signed(simm)}; dst = rt; wr = 1;
                end
                msec_pkg::OP_J: npc = {seq[31:28], it.instr_word[25:0], 2'b00};
                default: r.bad_opcode = 1'b1;
            endcase
            if (wr && dst != 5'd0) begin
                arch_regs[dst] = val;
                r.reg_written  = 1'b1;
                r.reg_index    = dst;
                r.reg_value    = val;
            end
            arch_pc = npc;
        end
        r.next_pc = arch_pc;
        return r;
    endfunction

    function automatic msec_pkg::t_in_item exec_item(logic [31:0] w);
        msec_pkg::t_in_item it;
        it.kind          = 1'b0;
        it.instr_word    = w;
        it.preload_index = 8'($urandom);
        it.preload_value = $urandom;
        return it;
    endfunction

    function automatic msec_pkg::t_in_item preload_item(logic [7:0] idx, logic [31:0] v);
        msec_pkg::t_in_item it;
        it.kind          = 1'b1;
        it.instr_word    = $urandom;
        it.preload_index = idx;
        it.preload_value = v;
        return it;
    endfunction

    function automatic logic [31:0] rfmt(logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [5:0] fn);
        return {msec_pkg::OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
    endfunction

    function automatic logic [31:0] ifmt(logic [5:0] op, logic [4:0] rs,
                                         logic [4:0] rt, logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [4:0] pick_reg();
        // Favor a few registers so results feed back into later operands.
        return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    // Random instruction, mostly well-formed with occasional noise.
    function automatic msec_pkg::t_in_item random_item();
        logic [5:0]  fns [8] = '{msec_pkg::FN_ADD, msec_pkg::FN_SUB, msec_pkg::FN_AND,
                                 msec_pkg::FN_OR, msec_pkg::FN_XOR, msec_pkg::FN_NOR,
                                 msec_pkg::FN_MUL, msec_pkg::FN_SLT};
        logic [15:0] imm;
        int          sel;
        sel = $urandom_range(0, 99);
        imm = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($signed(7'($urandom)));
        if (sel < 10) return preload_item(8'($urandom), $urandom);
        if (sel < 40) return exec_item(rfmt(pick_reg(), pick_reg(), pick_reg(),
                                            fns[$urandom_range(0, 7)]));
        if (sel < 44) return exec_item(rfmt(pick_reg(), pick_reg(), pick_reg(),
                                            6'($urandom)));
        if (sel < 54) return exec_item(ifmt(msec_pkg::OP_LW, pick_reg(), pick_reg(), imm));
        if (sel < 64) return exec_item(ifmt(msec_pkg::OP_SW, pick_reg(), pick_reg(), imm));
        if (sel < 69) return exec_item(ifmt(msec_pkg::OP_BEQ, pick_reg(), pick_reg(), imm));
        if (sel < 74) return exec_item(ifmt(msec_pkg::OP_BNE, pick_reg(), pick_reg(), imm));
        if (sel < 86) return exec_item(ifmt(msec_pkg::OP_ADDI, pick_reg(), pick_reg(),
                                            16'($urandom)));
        if (sel < 91) return exec_item(ifmt(msec_pkg::OP_SLTI, pick_reg(), pick_reg(), imm));
        if (sel < 94) return exec_item({msec_pkg::OP_J, 26'($urandom)});
        return exec_item($urandom);
    endfunction

    function automatic msec_pkg::t_out_item fixed_result(logic [31:0] pc, bit bad,
                                               bit mw, logic [7:0] mi, logic [31:0] mv);
        msec_pkg::t_out_item r;
        r = '0;
        r.next_pc     = pc;
        r.bad_opcode  = bad;
        r.mem_written = mw;
        r.mem_index   = mi;
        r.mem_value   = mv;
        return r;
    endfunction

    task automatic add_row(msec_pkg::t_in_item it);
        t_row row;
        row.item = it; row.has_fixed = 0; row.fixed = '0;
        table_rows.push_back(row);
    endtask

    task automatic add_fixed(msec_pkg::t_in_item it, msec_pkg::t_out_item r);
        t_row row;
        row.item = it; row.has_fixed = 1; row.fixed = r;
        table_rows.push_back(row);
    endtask

    // Hold the transaction until accepted, with random idle bursts before it.
    task automatic send(msec_pkg::t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Build the directed table: extremes, every operation, special cases.
    task automatic build_table();
        // After reset: preload at both index extremes, pc still zero.
        add_fixed(preload_item(8'd0, 32'hffff_ffff), fixed_result(32'd0, 0, 1, 8'd0,
                                                                  32'hffff_ffff));
        add_fixed(preload_item(8'd255, 32'h8000_0001), fixed_result(32'd0, 0, 1, 8'd255,
                                                                    32'h8000_0001));
        // Unknown opcode: flag and advance pc.
        add_fixed(exec_item(32'hffff_ffff), fixed_result(32'd4, 1, 0, 8'd0, 32'd0));
        add_row(exec_item(ifmt(msec_pkg::OP_ADDI, 5'd0, 5'd1, 16'h7fff)));
        add_row(exec_item(ifmt(msec_pkg::OP_ADDI, 5'd0, 5'd2, 16'h8000)));
        add_row(exec_item(ifmt(msec_pkg::OP_ADDI, 5'd0, 5'd0, 16'h1234))); // r0 dropped
        add_row(exec_item(rfmt(5'd1, 5'd2, 5'd3, msec_pkg::FN_ADD)));
        add_row(exec_item(rfmt(5'd1, 5'd2, 5'd4, msec_pkg::FN_SUB)));
        add_row(exec_item(rfmt(5'd1, 5'd2, 5'd5, msec_pkg::FN_AND)));
        add_row(exec_item(rfmt(5'd1, 5'd2, 5'd6, msec_pkg::FN_OR)));
        add_row(exec_item(rfmt(5'd1, 5'd2, 5'd7, msec_pkg::FN_XOR)));
        add_row(exec_item(rfmt(5'd1, 5'd2, 5'd31, msec_pkg::FN_NOR)));
        add_row(exec_item(rfmt(5'd31, 5'd31, 5'd8, msec_pkg::FN_MUL)));
        add_row(exec_item(rfmt(5'd2, 5'd1, 5'd9, msec_pkg::FN_SLT)));   // signed compare
        add_row(exec_item(rfmt(5'd1, 5'd2, 5'd10, 6'h3f)));             // unknown funct
        add_row(exec_item(ifmt(msec_pkg::OP_SLTI, 5'd2, 5'd11, 16'hffff)));
        add_row(exec_item(ifmt(msec_pkg::OP_LW, 5'd0, 5'd12, 16'hfffc))); // last word
        add_row(exec_item(ifmt(msec_pkg::OP_SW, 5'd31, 5'd1, 16'h0003))); // low bits
        add_row(exec_item(ifmt(msec_pkg::OP_LW, 5'd0, 5'd13, 16'h0000)));
        add_row(exec_item(ifmt(msec_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000)));
        add_row(exec_item(ifmt(msec_pkg::OP_BNE, 5'd1, 5'd0, 16'h7fff)));
        add_row(exec_item(ifmt(msec_pkg::OP_BNE, 5'd0, 5'd0, 16'h0010))); // not taken
        add_row(exec_item({msec_pkg::OP_J, 26'h3ff_ffff}));
        add_row(exec_item({msec_pkg::OP_J, 26'h000_0000}));
    endtask

    // Receiver: random stall bursts, then compare each result field by field.
    initial begin
        int burst;
        i_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 16);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        msec_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.next_pc !== want.next_pc) begin
                    $display("%0t: next_pc expected %h actual %h", $time, want.next_pc,
                             o_data.next_pc);
                    errors++;
                end
                if (o_data.reg_written !== want.reg_written ||
                    o_data.reg_index !== want.reg_index ||
                    o_data.reg_value !== want.reg_value) begin
                    $display("%0t: reg write expected %b/%0d/%h actual %b/%0d/%h", $time,
                             want.reg_written, want.reg_index, want.reg_value,
                             o_data.reg_written, o_data.reg_index, o_data.reg_value);
                    errors++;
                end
                if (o_data.mem_written !== want.mem_written ||
                    o_data.mem_index !== want.mem_index ||
                    o_data.mem_value !== want.mem_value) begin
                    $display("%0t: mem write expected %b/%0d/%h actual %b/%0d/%h", $time,
                             want.mem_written, want.mem_index, want.mem_value,
                             o_data.mem_written, o_data.mem_index, o_data.mem_value);
                    errors++;
                end
                if (o_data.bad_opcode !== want.bad_opcode) begin
                    $display("%0t: bad_opcode expected %b actual %b", $time,
                             want.bad_opcode, o_data.bad_opcode);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random run, drain.
    initial begin
        msec_pkg::t_out_item want;
        errors      = 0;
        idle_cycles = 0;
        quiet       = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        arch_pc     = '0;
        foreach (arch_regs[k]) arch_regs[k] = '0;
        foreach (arch_dmem[k]) arch_dmem[k] = '0;
        build_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; typed-in results must agree with the predictor.
        foreach (table_rows[k]) begin
            want = retire(table_rows[k].item);
            if (table_rows[k].has_fixed && want !== table_rows[k].fixed) begin
                $display("%0t: table row %0d expected %h predicted %h", $time, k,
                         table_rows[k].fixed, want);
                errors++;
            end
            pending_results.push_back(table_rows[k].has_fixed ? table_rows[k].fixed : want);
            send(table_rows[k].item);
        end

        // Random part; drop idling for the last stretch.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            msec_pkg::t_in_item it;
            if (n == RANDOM_ITEMS - 100) quiet = 1;
            it = random_item();
            pending_results.push_back(retire(it));
            send(it);
        end
        i_valid <= 1'b0;

        // Drain: the watchdog bounds this wait.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
